### rtl/b32enc_pkg.sv
`default_nettype none

package b32enc_pkg;

    localparam int CHK_W = 30;
    localparam int SYM_W = 5;
    localparam int CHAR_W = 7;

    // checksum start value, also the final xor constant
    localparam logic [CHK_W-1:0] CHK_INIT = 30'd1;

    localparam logic [CHK_W-1:0] GEN [5] = '{
        30'h3b6a57b2,
        30'h26508e6d,
        30'h1ea119fa,
        30'h3d4233dd,
        30'h2a1462b3
    };

    // symbol alphabet, index 0 first
    localparam logic [CHAR_W-1:0] SYM_CHARS [32] = '{
        7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
        7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
        7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
        7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
    };

    localparam logic [CHAR_W-1:0] CHAR_SEPARATOR = 7'h31;
    localparam logic [CHAR_W-1:0] CHAR_B = 7'h62;
    localparam logic [CHAR_W-1:0] CHAR_I = 7'h69;
    localparam logic [CHAR_W-1:0] CHAR_O = 7'h6f;

    localparam logic [63:0] PREFIX_RESET = 64'h6362;
    localparam logic [3:0] PREFIX_LEN_RESET = 4'd2;
    localparam logic [SYM_W-1:0] VERSION_RESET = 5'd0;

    // configuration register indexes
    localparam logic [1:0] CFG_PREFIX_CHARS = 2'd0;
    localparam logic [1:0] CFG_PREFIX_LENGTH = 2'd1;
    localparam logic [1:0] CFG_WITNESS_VERSION = 2'd2;

    typedef struct packed {
        logic             init;
        logic             step;
        logic [SYM_W-1:0] sym;
    } t_fold_req;

endpackage

`default_nettype wire

### rtl/b32enc_polymod.sv
`default_nettype none

module b32enc_polymod (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  b32enc_pkg::t_fold_req                i_req,
    output logic [b32enc_pkg::CHK_W-1:0]         o_chk
);

    logic [b32enc_pkg::CHK_W-1:0] r_chk;
    logic [b32enc_pkg::CHK_W-1:0] n_chk;
    logic [4:0]                   top;

    always_comb begin
        top = r_chk[29:25];
        n_chk = {r_chk[24:0], i_req.sym};
        for (int k = 0; k < 5; k++) begin
            if (top[k]) begin
                n_chk = n_chk ^ b32enc_pkg::GEN[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= b32enc_pkg::CHK_INIT;
        end else if (i_req.init) begin
            r_chk <= b32enc_pkg::CHK_INIT;
        end else if (i_req.step) begin
            r_chk <= n_chk;
        end
    end

    assign o_chk = r_chk;

endmodule

`default_nettype wire

### rtl/bech32_address_encoder.sv
// channel   handshake                  payload                          dir
// -------   ------------------------   ------------------------------   ---
// input     i_in_valid, o_in_stall     i_program_byte, i_final_byte     in
// output    o_out_valid, i_out_stall   o_out_char, o_final_char         out
// config    i_cfg_valid, o_cfg_ready   i_cfg_index, i_cfg_data          in
//
// a byte is accepted in idle and then gives one or two 5-bit symbols, one per cycle unless the output stalls
// the first byte of a message first folds the prefix high bits and a zero, then emits prefix chars, separator, version
// the final byte then takes a pad step, six zero folds and six checksum chars
// every symbol fold goes through the single polymod unit, one fold per cycle unless an output stall holds it
// an output stall freezes the emitting step; the input is stalled until the byte is done
// reset is synchronous and leaves no message open
`default_nettype none

module bech32_address_encoder #(
    parameter int MAX_PREFIX_CHARS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_program_byte,
    input  wire         i_final_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [6:0]  o_out_char,
    output logic        o_final_char,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);

    localparam int PFX_W = 8 * MAX_PREFIX_CHARS;
    localparam int IDX_W = (MAX_PREFIX_CHARS > 1) ? $clog2(MAX_PREFIX_CHARS) : 1;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PFX_HI  = 4'd1;
    localparam logic [3:0] ST_PFX_SEP = 4'd2;
    localparam logic [3:0] ST_PFX_LO  = 4'd3;
    localparam logic [3:0] ST_ONE     = 4'd4;
    localparam logic [3:0] ST_VER     = 4'd5;
    localparam logic [3:0] ST_DATA    = 4'd6;
    localparam logic [3:0] ST_PAD     = 4'd7;
    localparam logic [3:0] ST_ZERO    = 4'd8;
    localparam logic [3:0] ST_OUT     = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [PFX_W-1:0] r_prefix;
    logic [3:0]       r_prefix_len;
    logic [4:0]       r_version;
    logic [3:0]       r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [11:0]      r_acc, n_acc;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_fin, n_fin;
    logic [3:0]       r_left_bits, n_left_bits;
    logic [2:0]       r_left_cnt, n_left_cnt;
    logic             r_open, n_open;
    logic [2:0]       r_step, n_step;
    logic             r_out_valid;
    logic [6:0]       r_out_char;
    logic             r_out_final;

    b32enc_pkg::t_fold_req        fold_req;
    logic [b32enc_pkg::CHK_W-1:0] chk;
    logic [b32enc_pkg::CHK_W-1:0] chk_pm;
    logic                         out_free;
    logic                         emit;
    logic [6:0]                   emit_char;
    logic                         emit_final;
    logic [7:0]                   cur_char;
    logic [3:0]                   sat_len;
    logic                         idx_last;
    logic [3:0]                   data_sh;
    logic [4:0]                   data_sym;
    logic [3:0]                   left_mask;
    logic [4:0]                   pad_sym;
    logic [4:0]                   fin_sym;

    b32enc_polymod u_polymod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fold_req),
        .o_chk   (chk)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix     <= PFX_W'(b32enc_pkg::PREFIX_RESET);
            r_prefix_len <= b32enc_pkg::PREFIX_LEN_RESET;
            r_version    <= b32enc_pkg::VERSION_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                b32enc_pkg::CFG_PREFIX_CHARS:    r_prefix     <= i_cfg_data[PFX_W-1:0];
                b32enc_pkg::CFG_PREFIX_LENGTH:   r_prefix_len <= i_cfg_data[3:0];
                b32enc_pkg::CFG_WITNESS_VERSION: r_version    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        cur_char  = r_prefix[8*r_idx +: 8];
        sat_len   = (r_prefix_len > 4'(MAX_PREFIX_CHARS)) ? 4'(MAX_PREFIX_CHARS)
                                                          : r_prefix_len;
        idx_last  = (4'(r_idx) == r_len - 4'd1);
        data_sh   = r_cnt - 4'd5;
        data_sym  = 5'(r_acc >> data_sh);
        left_mask = 4'((5'd1 << data_sh[2:0]) - 5'd1);
        pad_sym   = 5'({1'b0, r_left_bits} << (3'd5 - r_left_cnt));
        chk_pm    = chk ^ b32enc_pkg::CHK_INIT;
        case (r_step)
            3'd0:    fin_sym = chk_pm[29:25];
            3'd1:    fin_sym = chk_pm[24:20];
            3'd2:    fin_sym = chk_pm[19:15];
            3'd3:    fin_sym = chk_pm[14:10];
            3'd4:    fin_sym = chk_pm[9:5];
            default: fin_sym = chk_pm[4:0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_fin       = r_fin;
        n_left_bits = r_left_bits;
        n_left_cnt  = r_left_cnt;
        n_open      = r_open;
        n_step      = r_step;
        fold_req    = '0;
        emit        = 1'b0;
        emit_char   = '0;
        emit_final  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_acc = {r_left_bits, i_program_byte};
                    n_cnt = {1'b0, r_left_cnt} + 4'd8;
                    n_fin = i_final_byte;
                    if (!r_open) begin
                        fold_req.init = 1'b1;
                        n_len = sat_len;
                        n_idx = '0;
                        n_state = (sat_len == 4'd0) ? ST_PFX_SEP : ST_PFX_HI;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_PFX_HI: begin
                fold_req.step = 1'b1;
                fold_req.sym  = {2'b00, cur_char[7:5]};
                n_idx = r_idx + 1'b1;
                if (idx_last) begin
                    n_idx = '0;
                    n_state = ST_PFX_SEP;
                end
            end
            ST_PFX_SEP: begin
                fold_req.step = 1'b1;
                n_state = (r_len == 4'd0) ? ST_ONE : ST_PFX_LO;
            end
            ST_PFX_LO: begin
                if (out_free) begin
                    fold_req.step = 1'b1;
                    fold_req.sym  = cur_char[4:0];
                    emit      = 1'b1;
                    emit_char = cur_char[6:0];
                    n_idx = r_idx + 1'b1;
                    if (idx_last) begin
                        n_state = ST_ONE;
                    end
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = b32enc_pkg::CHAR_SEPARATOR;
                    n_state   = ST_VER;
                end
            end
            ST_VER: begin
                if (out_free) begin
                    fold_req.step = 1'b1;
                    fold_req.sym  = r_version;
                    emit      = 1'b1;
                    emit_char = b32enc_pkg::SYM_CHARS[r_version];
                    n_open    = 1'b1;
                    n_state   = ST_DATA;
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    fold_req.step = 1'b1;
                    fold_req.sym  = data_sym;
                    emit      = 1'b1;
                    emit_char = b32enc_pkg::SYM_CHARS[data_sym];
                    n_cnt = data_sh;
                    // fewer than five bits left: park them for the next byte
                    if (data_sh < 4'd5) begin
                        n_left_bits = r_acc[3:0] & left_mask;
                        n_left_cnt  = data_sh[2:0];
                        n_state     = r_fin ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                if (r_left_cnt == 3'd0) begin
                    n_step  = '0;
                    n_state = ST_ZERO;
                end else if (out_free) begin
                    fold_req.step = 1'b1;
                    fold_req.sym  = pad_sym;
                    emit      = 1'b1;
                    emit_char = b32enc_pkg::SYM_CHARS[pad_sym];
                    n_step    = '0;
                    n_state   = ST_ZERO;
                end
            end
            ST_ZERO: begin
                fold_req.step = 1'b1;
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_step  = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_char  = b32enc_pkg::SYM_CHARS[fin_sym];
                    emit_final = (r_step == 3'd5);
                    n_step     = r_step + 3'd1;
                    if (r_step == 3'd5) begin
                        fold_req.init = 1'b1;
                        n_left_bits   = '0;
                        n_left_cnt    = '0;
                        n_open        = 1'b0;
                        n_step        = '0;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left_bits <= '0;
            r_left_cnt  <= '0;
            r_open      <= 1'b0;
            r_step      <= '0;
            r_idx       <= '0;
            r_len       <= '0;
        end else begin
            r_state     <= n_state;
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
            r_open      <= n_open;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_len       <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_fin <= n_fin;
    end

    // output register, refilled in the cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char  <= emit_char;
            r_out_final <= emit_final;
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_final_char = r_out_final;

endmodule

`default_nettype wire

### rtl/b32enc_checker.sv
`default_nettype none

module b32enc_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        o_in_stall,
    input  wire        o_out_valid,
    input  wire        i_out_stall,
    input  wire [6:0]  o_out_char,
    input  wire        o_final_char
);

    // a held result keeps its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_char) && $stable(o_final_char))
        else $error("held result changed");

    // reset leaves the block empty and ready for a request
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // every accepted byte makes the block busy in the following cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("byte accepted without busy cycle");

    // the flagged character is a checksum symbol, never separator or excluded letters
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_final_char |->
            o_out_char != b32enc_pkg::CHAR_SEPARATOR && o_out_char != b32enc_pkg::CHAR_B &&
            o_out_char != b32enc_pkg::CHAR_I && o_out_char != b32enc_pkg::CHAR_O)
        else $error("final character outside the symbol alphabet");

endmodule

bind bech32_address_encoder b32enc_checker u_b32enc_checker (.*);

`default_nettype wire
